FILE: src/pwmscan_pkg.sv
// ----------------------------------------------------------------------------
// pwmscan_pkg
// Shared types, codes and the character encoder for the window scanner.
// ----------------------------------------------------------------------------
package pwmscan_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_FEED    = 2'd1,
        FUNC_RESTART = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CFG_MOTIF_LENGTH  = 2'd0,
        CFG_MASKED_LIMIT  = 2'd1,
        CFG_POSITION_BASE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    localparam logic [2:0] SYM_A     = 3'd0;
    localparam logic [2:0] SYM_T     = 3'd1;
    localparam logic [2:0] SYM_C     = 3'd2;
    localparam logic [2:0] SYM_G     = 3'd3;
    localparam logic [2:0] SYM_OTHER = 3'd4;

    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_GAP  = 8'h2D;
    localparam logic [7:0] CASE_LIMIT  = 8'd95;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam int SCORE_MAX = 1048575;
    localparam int SCORE_MIN = -1048576;
    localparam int SCORE_W   = 21;
    localparam int CFG_W     = 32;

    typedef struct packed {
        logic       masked;
        logic [2:0] sym;
    } base_code_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

    function automatic base_code_t encode_char(input logic [7:0] c);
        base_code_t r;
        logic [7:0] u;
        r.masked = (c == CHAR_GAP) || (c == CHAR_N);
        u = (c > CASE_LIMIT) ? (c - CASE_OFFSET) : c;
        case (u)
            CHAR_A:  r.sym = SYM_A;
            CHAR_T:  r.sym = SYM_T;
            CHAR_C:  r.sym = SYM_C;
            CHAR_G:  r.sym = SYM_G;
            default: r.sym = SYM_OTHER;
        endcase
        return r;
    endfunction

endpackage

FILE: src/pwm_log_odds_window_scan.sv
// ----------------------------------------------------------------------------
// pwm_log_odds_window_scan
// Position weight matrix log-odds scanner over a sliding window of bases.
// ----------------------------------------------------------------------------
// Weight loads, restarts and bases that do not yet fill the window are
// accepted back to back while idle. A base that completes a window holds
// off the next transaction until its result is loaded: the window ring of
// cells rotates once per position past its tail, each position costs one
// read of the single weight RAM port, a drain state adds the last read, and
// an emit state loads the output register once the sink has freed it.
// Weights must be loaded before the positions that use them are scored.
module pwm_log_odds_window_scan #(
    parameter int MAX_LEN      = 32,
    parameter int WEIGHT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_index,
    input  logic [31:0]         cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [6:0]          s_weight_index,
    input  logic signed [15:0]  s_weight_value,
    input  logic [7:0]          s_base_char,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [20:0]  m_score,
    output logic                m_scored,
    output logic [31:0]         m_window_start,
    output logic [5:0]          m_masked_count
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int DEPTH  = MAX_LEN * 4;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = WEIGHT_WIDTH + IDX_W + 1;
    localparam int W_MAX  = (2 ** (WEIGHT_WIDTH - 1)) - 1;
    localparam int W_MIN  = -W_MAX - 1;

    // configuration
    logic [5:0]  motif_length_reg;
    logic [5:0]  masked_limit_reg;
    logic [31:0] position_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motif_length_reg  <= 6'd8;
            masked_limit_reg  <= 6'd3;
            position_base_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                pwmscan_pkg::CFG_MOTIF_LENGTH:  motif_length_reg  <= cfg_wr_data[5:0];
                pwmscan_pkg::CFG_MASKED_LIMIT:  masked_limit_reg  <= cfg_wr_data[5:0];
                pwmscan_pkg::CFG_POSITION_BASE: position_base_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] len_m1;
    logic [IDX_W-1:0] tail_idx;

    always_comb begin
        if (motif_length_reg == 6'd0) begin
            eff_len = LEN_W'(1);
        end else if (int'(motif_length_reg) > MAX_LEN) begin
            eff_len = LEN_W'(MAX_LEN);
        end else begin
            eff_len = LEN_W'(motif_length_reg);
        end
    end

    assign len_m1   = eff_len - LEN_W'(1);
    assign tail_idx = len_m1[IDX_W-1:0];

    // state
    pwmscan_pkg::state_t state_reg, state_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [31:0]             base_cnt_reg, base_cnt_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [31:0]             start_reg, start_next;
    logic [LEN_W-1:0]        masked_reg, masked_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    add_valid_reg, add_valid_next;

    logic m_valid_reg, m_valid_next;
    logic signed [20:0] m_score_reg, m_score_next;
    logic        m_scored_reg, m_scored_next;
    logic [31:0] m_window_start_reg, m_window_start_next;
    logic [5:0]  m_masked_count_reg, m_masked_count_next;

    logic in_accept;
    logic is_load, is_feed, is_restart;
    logic fill_sat;
    logic out_free;
    logic scan_active;
    logic emit_load;

    assign in_accept  = s_valid && s_ready;
    assign is_load    = in_accept && (s_func == pwmscan_pkg::FUNC_LOAD);
    assign is_feed    = in_accept && (s_func == pwmscan_pkg::FUNC_FEED);
    assign is_restart = in_accept && (s_func == pwmscan_pkg::FUNC_RESTART);
    assign fill_sat   = fill_reg >= LEN_W'(MAX_LEN);
    assign out_free   = !m_valid_reg || m_ready;

    logic [LEN_W-1:0] fill_inc;
    assign fill_inc = fill_sat ? fill_reg : (fill_reg + LEN_W'(1));

    // window chain
    pwmscan_pkg::cell_ctrl_t  cell_ctrl;
    pwmscan_pkg::base_code_t  cell_codes [MAX_LEN];
    pwmscan_pkg::base_code_t  chain_in   [MAX_LEN];
    pwmscan_pkg::base_code_t  tail_code;
    pwmscan_pkg::base_code_t  new_code;

    assign new_code  = pwmscan_pkg::encode_char(s_base_char);
    assign tail_code = cell_codes[tail_idx];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++) begin : g_cells
            if (gi == 0) begin : g_head
                assign chain_in[gi] = cell_ctrl.shift ? new_code : tail_code;
            end else begin : g_body
                assign chain_in[gi] = cell_codes[gi-1];
            end
            pwmscan_cell #(
                .CELL_INDEX (gi),
                .LEN_W      (LEN_W)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl),
                .len      (eff_len),
                .code_in  (chain_in[gi]),
                .code_out (cell_codes[gi])
            );
        end
    endgenerate

    // weight memory
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [WEIGHT_WIDTH-1:0] ram_wr_data;
    logic [ADDR_W-1:0]       ram_rd_addr;
    logic [WEIGHT_WIDTH-1:0] ram_rd_data;
    logic signed [31:0]      wval;

    assign wval        = 32'(s_weight_value);
    assign ram_wr_en   = is_load && (int'(s_weight_index) < DEPTH);
    assign ram_wr_addr = ADDR_W'(s_weight_index);
    assign ram_rd_addr = {step_reg, tail_code.sym[1:0]};

    always_comb begin
        if (wval > W_MAX) begin
            ram_wr_data = WEIGHT_WIDTH'(W_MAX);
        end else if (wval < W_MIN) begin
            ram_wr_data = WEIGHT_WIDTH'(W_MIN);
        end else begin
            ram_wr_data = wval[WEIGHT_WIDTH-1:0];
        end
    end

    pwmscan_ram #(
        .WIDTH (WEIGHT_WIDTH),
        .DEPTH (DEPTH)
    ) u_weights (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pwmscan_pkg::ST_IDLE: begin
                if (is_feed && (fill_inc >= eff_len)) begin
                    state_next = pwmscan_pkg::ST_SCAN;
                end
            end
            pwmscan_pkg::ST_SCAN: begin
                if (step_reg == tail_idx) begin
                    state_next = pwmscan_pkg::ST_DRAIN;
                end
            end
            pwmscan_pkg::ST_DRAIN: begin
                state_next = pwmscan_pkg::ST_EMIT;
            end
            pwmscan_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = pwmscan_pkg::ST_IDLE;
                end
            end
            default: state_next = pwmscan_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready          = 1'b0;
        scan_active      = 1'b0;
        emit_load        = 1'b0;
        case (state_reg)
            pwmscan_pkg::ST_IDLE:  s_ready     = 1'b1;
            pwmscan_pkg::ST_SCAN:  scan_active = 1'b1;
            pwmscan_pkg::ST_DRAIN: ;
            pwmscan_pkg::ST_EMIT:  emit_load   = out_free;
            default: ;
        endcase
        cell_ctrl.shift  = is_feed;
        cell_ctrl.rotate = scan_active;
    end

    // datapath
    logic signed [31:0] acc_wide;
    logic               win_scored;

    assign acc_wide   = 32'(acc_reg);
    assign win_scored = 32'(masked_reg) < 32'(masked_limit_reg);

    always_comb begin
        fill_next      = fill_reg;
        base_cnt_next  = base_cnt_reg;
        step_next      = step_reg;
        start_next     = start_reg;
        masked_next    = masked_reg;
        acc_next       = acc_reg;
        add_valid_next = 1'b0;

        if (is_restart) begin
            fill_next     = '0;
            base_cnt_next = 32'd0;
        end

        if (is_feed) begin
            fill_next     = fill_inc;
            base_cnt_next = base_cnt_reg + 32'd1;
            start_next    = position_base_reg + base_cnt_reg + 32'd1 - 32'(eff_len);
            step_next     = '0;
            masked_next   = '0;
            acc_next      = '0;
        end

        if (scan_active) begin
            step_next      = step_reg + IDX_W'(1);
            masked_next    = masked_reg + LEN_W'(tail_code.masked);
            add_valid_next = !tail_code.sym[2];
        end

        if (add_valid_reg) begin
            acc_next = acc_reg + ACC_W'(signed'(ram_rd_data));
        end
    end

    // result register
    logic [31:0] masked_wide;
    assign masked_wide = 32'(masked_reg);

    always_comb begin
        m_valid_next        = m_valid_reg;
        m_score_next        = m_score_reg;
        m_scored_next       = m_scored_reg;
        m_window_start_next = m_window_start_reg;
        m_masked_count_next = m_masked_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_load) begin
            m_valid_next        = 1'b1;
            m_scored_next       = win_scored;
            m_window_start_next = start_reg;
            m_masked_count_next = masked_wide[5:0];
            if (!win_scored) begin
                m_score_next = '0;
            end else if (acc_wide > pwmscan_pkg::SCORE_MAX) begin
                m_score_next = pwmscan_pkg::SCORE_W'(pwmscan_pkg::SCORE_MAX);
            end else if (acc_wide < pwmscan_pkg::SCORE_MIN) begin
                m_score_next = pwmscan_pkg::SCORE_W'(pwmscan_pkg::SCORE_MIN);
            end else begin
                m_score_next = acc_wide[20:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pwmscan_pkg::ST_IDLE;
            fill_reg      <= '0;
            base_cnt_reg  <= 32'd0;
            add_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            base_cnt_reg  <= base_cnt_next;
            add_valid_reg <= add_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg           <= step_next;
        start_reg          <= start_next;
        masked_reg         <= masked_next;
        acc_reg            <= acc_next;
        m_score_reg        <= m_score_next;
        m_scored_reg       <= m_scored_next;
        m_window_start_reg <= m_window_start_next;
        m_masked_count_reg <= m_masked_count_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_score        = m_score_reg;
    assign m_scored       = m_scored_reg;
    assign m_window_start = m_window_start_reg;
    assign m_masked_count = m_masked_count_reg;

endmodule

FILE: src/pwmscan_ram.sv
// ----------------------------------------------------------------------------
// pwmscan_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pwmscan_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/pwmscan_cell.sv
// ----------------------------------------------------------------------------
// pwmscan_cell
// One window slot: holds a base code, shifts on a new base and rotates
// within the active window ring during a scan.
// ----------------------------------------------------------------------------
module pwmscan_cell #(
    parameter int CELL_INDEX = 0,
    parameter int LEN_W      = 6
) (
    input  logic                     aclk,
    input  pwmscan_pkg::cell_ctrl_t  ctrl,
    input  logic [LEN_W-1:0]         len,
    input  pwmscan_pkg::base_code_t  code_in,
    output pwmscan_pkg::base_code_t  code_out
);

    pwmscan_pkg::base_code_t code_reg;
    pwmscan_pkg::base_code_t code_next;
    logic                    in_ring;

    assign in_ring = len > LEN_W'(CELL_INDEX);

    always_comb begin
        code_next = code_reg;
        if (ctrl.shift || (ctrl.rotate && in_ring)) begin
            code_next = code_in;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign code_out = code_reg;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the window scanner: the bench keeps its own copy of
// the weight table, base window and counters, predicts every window result,
// and compares each result transaction field by field while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int          WIN_MAX     = 32;
    localparam int          TABLE_SIZE  = WIN_MAX * 4;
    localparam int          HOLD_CYCLES = 300;
    localparam int          SETTLE      = WIN_MAX + 8;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          REPORT_MAX  = 10;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;

    typedef struct {
        logic signed [20:0] score;
        logic               scored;
        logic [31:0]        start;
        logic [5:0]         masked;
    } window_result_t;

    class window_scoreboard;
        pwmscan_pkg::base_code_t window_q [WIN_MAX];
        logic signed [15:0]      weight_mem [TABLE_SIZE];
        int unsigned             fill;
        logic [31:0]             base_idx;
        logic [5:0]              motif_len;
        logic [5:0]              mask_lim;
        logic [31:0]             pos_base;
        window_result_t          due_windows [$];
        int unsigned             faults;

        function new();
            foreach (window_q[i]) window_q[i] = '0;
            foreach (weight_mem[i]) weight_mem[i] = '0;
            fill      = 0;
            base_idx  = '0;
            motif_len = 6'd8;
            mask_lim  = 6'd3;
            pos_base  = '0;
            faults    = 0;
        endfunction

        function void set_reg(pwmscan_pkg::cfg_index_t idx, logic [31:0] val);
            case (idx)
                pwmscan_pkg::CFG_MOTIF_LENGTH:  motif_len = val[5:0];
                pwmscan_pkg::CFG_MASKED_LIMIT:  mask_lim  = val[5:0];
                pwmscan_pkg::CFG_POSITION_BASE: pos_base  = val;
                default: ;
            endcase
        endfunction

        function pwmscan_pkg::base_code_t classify(logic [7:0] ch);
            pwmscan_pkg::base_code_t e;
            logic [7:0] up;
            e.masked = (ch == pwmscan_pkg::CHAR_GAP) || (ch == pwmscan_pkg::CHAR_N);
            up = (ch > pwmscan_pkg::CASE_LIMIT) ? ch - pwmscan_pkg::CASE_OFFSET : ch;
            if (up == pwmscan_pkg::CHAR_A)
                e.sym = pwmscan_pkg::SYM_A;
            else if (up == pwmscan_pkg::CHAR_T)
                e.sym = pwmscan_pkg::SYM_T;
            else if (up == pwmscan_pkg::CHAR_C)
                e.sym = pwmscan_pkg::SYM_C;
            else if (up == pwmscan_pkg::CHAR_G)
                e.sym = pwmscan_pkg::SYM_G;
            else
                e.sym = pwmscan_pkg::SYM_OTHER;
            return e;
        endfunction

        function int unsigned window_len();
            if (motif_len == 0)
                return 1;
            if (motif_len > WIN_MAX)
                return WIN_MAX;
            return motif_len;
        endfunction

        function void clear_window();
            foreach (window_q[i]) window_q[i] = '0;
            fill     = 0;
            base_idx = '0;
        endfunction

        // shift in one base and queue the window score it produces, if any
        function void score_base(logic [7:0] ch);
            window_result_t          r;
            logic [31:0]             newest;
            int unsigned             len;
            int unsigned             nmask;
            int                      sum;
            pwmscan_pkg::base_code_t e;
            for (int i = WIN_MAX - 1; i > 0; i--)
                window_q[i] = window_q[i - 1];
            window_q[0] = classify(ch);
            newest   = base_idx;
            base_idx = base_idx + 32'd1;
            if (fill < WIN_MAX)
                fill++;
            len = window_len();
            if (fill < len)
                return;
            nmask = 0;
            sum   = 0;
            for (int j = 0; j < len; j++) begin
                e = window_q[len - 1 - j];
                if (e.masked)
                    nmask++;
                if (e.sym < pwmscan_pkg::SYM_OTHER)
                    sum += int'(weight_mem[j * 4 + int'(e.sym)]);
            end
            r.scored = (nmask < mask_lim);
            if (!r.scored)
                sum = 0;
            if (sum > pwmscan_pkg::SCORE_MAX)
                sum = pwmscan_pkg::SCORE_MAX;
            if (sum < pwmscan_pkg::SCORE_MIN)
                sum = pwmscan_pkg::SCORE_MIN;
            r.score  = sum[20:0];
            r.start  = pos_base + newest + 32'd1 - 32'(len);
            r.masked = nmask[5:0];
            due_windows.push_back(r);
        endfunction

        function void note_input(logic [1:0] fn, logic [6:0] wi, logic signed [15:0] wv,
                                 logic [7:0] ch);
            case (fn)
                pwmscan_pkg::FUNC_LOAD:    weight_mem[wi] = wv;
                pwmscan_pkg::FUNC_FEED:    score_base(ch);
                pwmscan_pkg::FUNC_RESTART: clear_window();
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [20:0] sc, logic sd, logic [31:0] st,
                                   logic [5:0] mc);
            window_result_t w;
            if (due_windows.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("unexpected window: score %0d scored %0d start %h masked %0d",
                             sc, sd, st, mc);
                return;
            end
            w = due_windows.pop_front();
            if (sc !== w.score || sd !== w.scored || st !== w.start || mc !== w.masked) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("window mismatch: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                             w.score, w.scored, w.start, w.masked, sc, sd, st, mc);
            end
        endfunction

        function int unsigned pending_count();
            return due_windows.size();
        endfunction

        function void close_out();
            if (due_windows.size() != 0) begin
                faults++;
                $display("%0d window results never arrived", due_windows.size());
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [1:0]         cfg_wr_index;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic [6:0]         s_weight_index;
    logic signed [15:0] s_weight_value;
    logic [7:0]         s_base_char;
    logic               m_valid;
    logic               m_ready;
    logic signed [20:0] m_score;
    logic               m_scored;
    logic [31:0]        m_window_start;
    logic [5:0]         m_masked_count;

    window_scoreboard   board;
    bit                 send_gaps;
    bit                 sink_gaps;
    bit                 hold_sink;
    int unsigned        cycles;

    pwm_log_odds_window_scan u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_weight_index (s_weight_index),
        .s_weight_value (s_weight_value),
        .s_base_char    (s_base_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_score        (m_score),
        .m_scored       (m_scored),
        .m_window_start (m_window_start),
        .m_masked_count (m_masked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(logic [1:0] fn, logic [6:0] wi, logic signed [15:0] wv,
                             logic [7:0] ch);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 4) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_func         = fn;
        s_weight_index = wi;
        s_weight_value = wv;
        s_base_char    = ch;
        do @(posedge aclk); while (!s_ready);
        board.note_input(fn, wi, wv, ch);
    endtask

    task automatic feed(logic [7:0] ch);
        send_item(pwmscan_pkg::FUNC_FEED, 7'($urandom_range(0, 127)), 16'($urandom), ch);
    endtask

    task automatic load_weight(logic [6:0] wi, logic signed [15:0] wv);
        send_item(pwmscan_pkg::FUNC_LOAD, wi, wv, 8'($urandom));
    endtask

    task automatic take_results();
        int unsigned gap;
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_sink = 1'b0;
            end
            gap = sink_gaps ? $urandom_range(0, 4) : 0;
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            board.check_result(m_score, m_scored, m_window_start, m_masked_count);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        take_results();
    end

    // wait for the last window, then give trailing loads or short feeds time to retire
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending_count() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(pwmscan_pkg::cfg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = val;
        board.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // upper bits of the narrow registers carry noise
    task automatic configure(logic [5:0] mlen, logic [5:0] mlim, logic [31:0] pbase);
        write_reg(pwmscan_pkg::CFG_MOTIF_LENGTH, ($urandom() & 32'hFFFF_FFC0) | 32'(mlen));
        write_reg(pwmscan_pkg::CFG_MASKED_LIMIT, ($urandom() & 32'hFFFF_FFC0) | 32'(mlim));
        write_reg(pwmscan_pkg::CFG_POSITION_BASE, pbase);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] nuc [4];
        int unsigned r;
        nuc = '{pwmscan_pkg::CHAR_A, pwmscan_pkg::CHAR_T,
                pwmscan_pkg::CHAR_C, pwmscan_pkg::CHAR_G};
        r = $urandom_range(0, 99);
        if (r < 72)
            return nuc[$urandom_range(0, 3)] | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        if (r < 80)
            return pwmscan_pkg::CHAR_N;
        if (r < 86)
            return pwmscan_pkg::CHAR_GAP;
        if (r < 89)
            return pwmscan_pkg::CHAR_N | 8'h20;
        return 8'($urandom);
    endfunction

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 78)
            feed(pick_char());
        else if (r < 91)
            load_weight(7'($urandom_range(0, 127)), 16'($urandom));
        else if (r < 94)
            send_item(pwmscan_pkg::FUNC_RESTART, 7'($urandom), 16'($urandom), 8'($urandom));
        else
            send_item(FUNC_UNUSED, 7'($urandom), 16'($urandom), 8'($urandom));
    endtask

    initial begin
        logic [5:0]  mlen;
        logic [5:0]  mlim;
        logic [31:0] pbase;
        board          = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = pwmscan_pkg::CFG_MOTIF_LENGTH;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_func         = pwmscan_pkg::FUNC_LOAD;
        s_weight_index = '0;
        s_weight_value = '0;
        s_base_char    = '0;
        send_gaps      = 1'b1;
        sink_gaps      = 1'b1;
        hold_sink      = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // whole table: A weights at the minimum, G at the maximum, T and C random
        for (int i = 0; i < TABLE_SIZE; i++) begin
            case (i % 4)
                0:       load_weight(7'(i), 16'sh8000);
                3:       load_weight(7'(i), 16'sh7FFF);
                default: load_weight(7'(i), 16'($urandom));
            endcase
        end
        // reset values of the registers
        repeat (12) feed(pick_char());
        settle();

        // single-base window, wrapping start, case folding and masking
        configure(6'd0, 6'd1, 32'hFFFF_FFFF);
        feed(pwmscan_pkg::CHAR_A);
        feed(pwmscan_pkg::CHAR_T | 8'h20);
        feed(pwmscan_pkg::CHAR_C | 8'h20);
        feed(pwmscan_pkg::CHAR_G);
        feed(pwmscan_pkg::CHAR_N);
        feed(pwmscan_pkg::CHAR_N | 8'h20);
        feed(pwmscan_pkg::CHAR_GAP);
        feed(8'h00);
        feed(8'hFF);
        feed(8'h7E);
        send_item(FUNC_UNUSED, 7'h7F, 16'sh7FFF, 8'hFF);
        load_weight(7'd0, 16'sh7FFF);
        feed(pwmscan_pkg::CHAR_A);
        load_weight(7'd0, 16'sh8000);
        feed(pwmscan_pkg::CHAR_A | 8'h20);
        send_item(pwmscan_pkg::FUNC_RESTART, 7'h55, 16'sh5555, 8'hAA);
        feed(pwmscan_pkg::CHAR_G);
        settle();

        // limit zero never scores
        configure(6'd2, 6'd0, 32'h0000_0010);
        feed(pwmscan_pkg::CHAR_A);
        feed(pwmscan_pkg::CHAR_C);
        feed(pwmscan_pkg::CHAR_G);
        settle();

        // full-width window at both ends of the score range
        configure(6'd63, 6'd63, $urandom());
        repeat (33) feed(pwmscan_pkg::CHAR_A);
        send_item(pwmscan_pkg::FUNC_RESTART, 7'($urandom), 16'($urandom), 8'($urandom));
        repeat (33) feed(pwmscan_pkg::CHAR_G | 8'h20);
        settle();

        for (int k = 0; k < 7; k++) begin
            case (k)
                0: begin mlen = 6'd32; mlim = 6'd32; pbase = 32'h0; end
                1: begin mlen = 6'd1;  mlim = 6'd0;  pbase = 32'hFFFF_FFFF; end
                2: begin mlen = 6'd5;  mlim = 6'd63; pbase = $urandom(); end
                default: begin
                    mlen  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(1, 8));
                    mlim  = ($urandom_range(0, 4) == 0) ? 6'd63 : 6'($urandom_range(0, 6));
                    pbase = $urandom();
                end
            endcase
            configure(mlen, mlim, pbase);
            send_gaps = (k % 4 == 0) || (k % 4 == 2);
            sink_gaps = (k % 4 == 0) || (k % 4 == 3);
            if (k == 2)
                hold_sink = 1'b1;
            repeat (140) random_item();
            settle();
        end

        board.close_out();
        if (board.faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/pwmscan_pkg.sv
src/pwmscan_ram.sv
src/pwmscan_cell.sv
src/pwm_log_odds_window_scan.sv
test/tb.sv
